// File: hw/rtl/allele_pileup_count_table_assert.svh
// Assertion macros shared by the allele pileup count table RTL.
`ifndef ALLELE_PILEUP_COUNT_TABLE_ASSERT_SVH
`define ALLELE_PILEUP_COUNT_TABLE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define APCT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define APCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/apct_pkg.sv
// Package with the shared types and constants of the allele pileup count table.
`timescale 1ns / 1ps

package apct_pkg;

	localparam logic [1:0] ACT_INIT    = 2'd0;
	localparam logic [1:0] ACT_OBSERVE = 2'd1;
	localparam logic [1:0] ACT_READ    = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNMATCHED = 2'd1;
	localparam logic [1:0] ST_SATURATED = 2'd2;

	localparam logic [7:0] BASE_A = 8'd65;
	localparam logic [3:0][7:0] BASE_ORDER = {8'd84, 8'd71, 8'd67, 8'd65};

	localparam logic [15:0] READ_DEPTH_RST = 16'd30;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_INIT,
		OP_OBSERVE,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [11:0] position;
		logic [7:0]  base;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  ref_base;
		logic [7:0]  alt_base;
		logic [15:0] ref_count;
		logic [15:0] alt_count;
	} res_t;

	typedef struct packed {
		logic busy;
		logic cmd_pop;
		logic res_push;
	} bk_stat_t;

endpackage

// File: hw/rtl/apct_fifo.sv
// Two-entry queue used between the front end, the back end and the result port.
`timescale 1ns / 1ps

module apct_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0] data_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = data_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			data_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: hw/rtl/apct_front.sv
// Front end that decodes an incoming transaction into a table command.
`timescale 1ns / 1ps

module apct_front #(
	parameter int POSITIONS = 4096
) (
	input  logic [1:0]        action,
	input  logic [11:0]       position,
	input  logic [7:0]        base_code,
	output apct_pkg::cmd_t    cmd
);

	logic in_range;
	apct_pkg::op_t op;

	assign in_range = {20'd0, position} < 32'(POSITIONS);

	always_comb begin
		unique case (action)
			apct_pkg::ACT_INIT:    op = apct_pkg::OP_INIT;
			apct_pkg::ACT_OBSERVE: op = apct_pkg::OP_OBSERVE;
			apct_pkg::ACT_READ:    op = apct_pkg::OP_READ;
			default:               op = apct_pkg::OP_NOP;
		endcase
		cmd.op       = in_range ? op : apct_pkg::OP_NOP;
		cmd.position = position;
		cmd.base     = base_code;
	end

endmodule

// File: hw/rtl/apct_back.sv
// Back end that reads, updates and writes back one table entry per command.
`timescale 1ns / 1ps

module apct_back #(
	parameter int POSITIONS  = 4096,
	parameter int COUNT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         read_depth,
	input  apct_pkg::cmd_t      cmd,
	input  logic                cmd_empty,
	input  logic                res_full,
	output apct_pkg::res_t      res,
	output apct_pkg::bk_stat_t  stat
);

	localparam int ADDR_W  = $clog2(POSITIONS);
	localparam int ENTRY_W = 32 + 4 * COUNT_BITS;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [31:0] CNT_MAX_W = 32'((64'd1 << COUNT_BITS) - 64'd1);

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_EXEC = 2'b10
	} bk_state_t;

	bk_state_t state_q;
	apct_pkg::cmd_t cmd_q;

	logic [ENTRY_W-1:0] mem_q [POSITIONS];
	logic [ENTRY_W-1:0] rd_data_q;
	logic [ENTRY_W-1:0] wr_data;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ADDR_W-1:0]  wr_addr;
	logic [31:0]        rd_pos_w;
	logic [31:0]        wr_pos_w;
	logic [31:0]        depth_w;

	logic [3:0][7:0]            bases;
	logic [3:0][COUNT_BITS-1:0] counts;
	logic [3:0][7:0]            new_bases;
	logic [3:0][COUNT_BITS-1:0] new_counts;
	logic [7:0]                 tmp_base;
	logic [COUNT_BITS-1:0]      tmp_count;
	logic [1:0]                 hit_idx;
	logic                       hit;
	logic                       wr_need;
	logic                       cmd_pop;
	logic                       res_push;

	function automatic logic [15:0] low16(input logic [COUNT_BITS-1:0] c);
		logic [31:0] w;
		w = 32'(c);
		return w[15:0];
	endfunction

	assign rd_pos_w = {20'd0, cmd.position};
	assign wr_pos_w = {20'd0, cmd_q.position};
	assign rd_addr  = rd_pos_w[ADDR_W-1:0];
	assign wr_addr  = wr_pos_w[ADDR_W-1:0];
	assign depth_w  = {16'd0, read_depth};

	assign cmd_pop  = (state_q == BK_IDLE) && !cmd_empty;
	assign res_push = (state_q == BK_EXEC) && !res_full;

	assign stat.busy     = state_q == BK_EXEC;
	assign stat.cmd_pop  = cmd_pop;
	assign stat.res_push = res_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			unique case (state_q)
				BK_IDLE: begin
					if (cmd_pop) begin
						state_q <= BK_EXEC;
					end
				end
				BK_EXEC: begin
					if (res_push) begin
						state_q <= BK_IDLE;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q     <= cmd;
			rd_data_q <= mem_q[rd_addr];
		end
		if (res_push && wr_need) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_comb begin
		bases      = rd_data_q[31:0];
		counts     = rd_data_q[ENTRY_W-1:32];
		new_bases  = bases;
		new_counts = counts;
		tmp_base   = '0;
		tmp_count  = '0;
		hit        = 1'b0;
		hit_idx    = 2'd0;
		wr_need    = 1'b0;
		res        = '0;
		case (cmd_q.op)
			apct_pkg::OP_INIT: begin
				wr_need      = 1'b1;
				new_bases[0] = cmd_q.base;
				for (int j = 1; j < 4; j++) begin
					new_bases[j] = (apct_pkg::BASE_ORDER[j] == cmd_q.base) ?
						apct_pkg::BASE_A : apct_pkg::BASE_ORDER[j];
					new_counts[j] = '0;
				end
				if (depth_w > CNT_MAX_W) begin
					new_counts[0] = CNT_MAX;
					res.status    = apct_pkg::ST_SATURATED;
				end else begin
					new_counts[0] = depth_w[COUNT_BITS-1:0];
				end
			end
			apct_pkg::OP_OBSERVE: begin
				if (bases[0] == cmd_q.base) begin
					hit = 1'b0;
				end else if (bases[1] == cmd_q.base) begin
					hit     = 1'b1;
					hit_idx = 2'd1;
				end else if (bases[2] == cmd_q.base) begin
					hit     = 1'b1;
					hit_idx = 2'd2;
				end else if (bases[3] == cmd_q.base) begin
					hit     = 1'b1;
					hit_idx = 2'd3;
				end else begin
					res.status = apct_pkg::ST_UNMATCHED;
				end
				if (hit) begin
					wr_need = 1'b1;
					if (counts[hit_idx] == CNT_MAX) begin
						res.status = apct_pkg::ST_SATURATED;
					end else begin
						new_counts[hit_idx] = counts[hit_idx] + COUNT_BITS'(1);
					end
					if (counts[0] == '0) begin
						res.status = apct_pkg::ST_SATURATED;
					end else begin
						new_counts[0] = counts[0] - COUNT_BITS'(1);
					end
				end
			end
			apct_pkg::OP_READ: begin
				wr_need = 1'b1;
				if (new_counts[1] < new_counts[2]) begin
					tmp_count     = new_counts[1];
					tmp_base      = new_bases[1];
					new_counts[1] = new_counts[2];
					new_bases[1]  = new_bases[2];
					new_counts[2] = tmp_count;
					new_bases[2]  = tmp_base;
				end
				if (new_counts[2] < new_counts[3]) begin
					tmp_count     = new_counts[2];
					tmp_base      = new_bases[2];
					new_counts[2] = new_counts[3];
					new_bases[2]  = new_bases[3];
					new_counts[3] = tmp_count;
					new_bases[3]  = tmp_base;
				end
				if (new_counts[1] < new_counts[2]) begin
					tmp_count     = new_counts[1];
					tmp_base      = new_bases[1];
					new_counts[1] = new_counts[2];
					new_bases[1]  = new_bases[2];
					new_counts[2] = tmp_count;
					new_bases[2]  = tmp_base;
				end
				res.ref_base  = new_bases[0];
				res.alt_base  = new_bases[1];
				res.ref_count = low16(new_counts[0]);
				res.alt_count = low16(new_counts[1]);
			end
			default: begin
				wr_need = 1'b0;
			end
		endcase
		wr_data = {new_counts, new_bases};
	end

endmodule

// File: hw/rtl/allele_pileup_count_table.sv
// Top level of the allele pileup count table with its queue ports.
`timescale 1ns / 1ps

// Each transaction pushed on the input queue is decoded by the front end, waits in a
// two-entry command queue and is executed by the back end: the idle state reads the
// position's entry from the single-port table memory and the execute state updates
// it, writes it back and places the result in a two-entry result queue, waiting while
// that queue is full. The back end holds one transaction at a time. Entries need no
// clearing after reset; a position must be initialized before it is observed or read.
module allele_pileup_count_table #(
	parameter int POSITIONS  = 4096,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  action,
	input  logic [11:0] position,
	input  logic [7:0]  base_code,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [7:0]  ref_base,
	output logic [7:0]  alt_base,
	output logic [15:0] ref_count,
	output logic [15:0] alt_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int CMD_W = $bits(apct_pkg::cmd_t);
	localparam int RES_W = $bits(apct_pkg::res_t);

	logic [15:0] read_depth_q;

	apct_pkg::cmd_t     cmd_in;
	apct_pkg::cmd_t     cmd_out;
	logic [CMD_W-1:0]   cmd_rdata;
	logic               cmd_empty;
	apct_pkg::res_t     res_in;
	apct_pkg::res_t     res_out;
	logic [RES_W-1:0]   res_rdata;
	logic               res_full;
	apct_pkg::bk_stat_t bk_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_depth_q <= apct_pkg::READ_DEPTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			read_depth_q <= cfg_data;
		end
	end

	apct_front #(
		.POSITIONS(POSITIONS)
	) u_front (
		.action   (action),
		.position (position),
		.base_code(base_code),
		.cmd      (cmd_in)
	);

	apct_fifo #(
		.WIDTH(CMD_W)
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cmd_in),
		.pop   (bk_stat.cmd_pop),
		.rdata (cmd_rdata),
		.full  (full),
		.empty (cmd_empty)
	);

	assign cmd_out = apct_pkg::cmd_t'(cmd_rdata);

	apct_back #(
		.POSITIONS (POSITIONS),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.read_depth(read_depth_q),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.res_full  (res_full),
		.res       (res_in),
		.stat      (bk_stat)
	);

	apct_fifo #(
		.WIDTH(RES_W)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (bk_stat.res_push),
		.wdata (res_in),
		.pop   (pop),
		.rdata (res_rdata),
		.full  (res_full),
		.empty (empty)
	);

	assign res_out   = apct_pkg::res_t'(res_rdata);
	assign status    = res_out.status;
	assign ref_base  = res_out.ref_base;
	assign alt_base  = res_out.alt_base;
	assign ref_count = res_out.ref_count;
	assign alt_count = res_out.alt_count;

`include "allele_pileup_count_table_assert.svh"

	`APCT_ASSERT_NOW(a_push_room, bk_stat.res_push, !res_full, "result pushed into a full queue")
	`APCT_ASSERT_NOW(a_pop_idle, bk_stat.cmd_pop, !cmd_empty && !bk_stat.busy, "bad command pop")
	`APCT_ASSERT_NEXT(a_pop_busy, bk_stat.cmd_pop, bk_stat.busy, "back end did not start")
	`APCT_ASSERT_NEXT(a_push_done, bk_stat.res_push, !bk_stat.busy, "back end did not finish")

endmodule

// File: dv/apct_pileup_checker.sv
// Checker that predicts and compares every result of the allele pileup count table.
`timescale 1ns / 1ps

module apct_pileup_checker
	import apct_pkg::*;
#(
	parameter int POSITIONS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  action,
	input  logic [11:0] position,
	input  logic [7:0]  base_code,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  status,
	input  logic [7:0]  ref_base,
	input  logic [7:0]  alt_base,
	input  logic [15:0] ref_count,
	input  logic [15:0] alt_count,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output int          pending,
	output int          fail_count,
	output int          results_seen
);

	localparam logic [15:0] CNT_MAX = '1;

	logic [3:0][7:0]  base_tbl [POSITIONS];
	logic [3:0][15:0] cnt_tbl [POSITIONS];
	logic [15:0]      depth_reg;
	res_t             pending_results [$];
	int               errs;
	int               seen;

	function automatic res_t pileup_apply(input logic [1:0] act, input logic [11:0] pos,
			input logic [7:0] base);
		res_t r;
		logic [3:0][7:0] b;
		logic [3:0][15:0] c;
		logic [7:0] tb;
		logic [15:0] tc;
		int i;
		int j;
		r = '0;
		r.status = ST_OK;
		if (int'(pos) >= POSITIONS) begin
			return r;
		end
		b = base_tbl[pos];
		c = cnt_tbl[pos];
		case (act)
			ACT_INIT: begin
				b[0] = base;
				for (j = 1; j < 4; j++) begin
					b[j] = (BASE_ORDER[j] == base) ? BASE_A : BASE_ORDER[j];
				end
				c = '0;
				c[0] = depth_reg;
			end
			ACT_OBSERVE: begin
				j = 0;
				while (j < 4 && b[j] != base) begin
					j++;
				end
				if (j == 4) begin
					r.status = ST_UNMATCHED;
				end else if (j > 0) begin
					if (c[j] == CNT_MAX) begin
						r.status = ST_SATURATED;
					end else begin
						c[j] = c[j] + 16'd1;
					end
					if (c[0] == '0) begin
						r.status = ST_SATURATED;
					end else begin
						c[0] = c[0] - 16'd1;
					end
				end
			end
			ACT_READ: begin
				for (i = 2; i < 4; i++) begin
					tc = c[i];
					tb = b[i];
					j = i;
					while (j > 1 && c[j - 1] < tc) begin
						c[j] = c[j - 1];
						b[j] = b[j - 1];
						j--;
					end
					c[j] = tc;
					b[j] = tb;
				end
				r.ref_base = b[0];
				r.alt_base = b[1];
				r.ref_count = c[0];
				r.alt_count = c[1];
			end
			default: begin
				return r;
			end
		endcase
		base_tbl[pos] = b;
		cnt_tbl[pos] = c;
		return r;
	endfunction

	function automatic int field_bad(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			pending_results.delete();
			depth_reg = READ_DEPTH_RST;
			errs = 0;
			seen = 0;
			pending <= 0;
			fail_count <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				depth_reg = cfg_data;
			end
			if (push && !full) begin
				pending_results.push_back(pileup_apply(action, position, base_code));
			end
			if (pop && !empty) begin
				got = {status, ref_base, alt_base, ref_count, alt_count};
				seen++;
				if (pending_results.size() == 0) begin
					$error("Result transaction arrived with no command outstanding.");
					errs++;
				end else begin
					want = pending_results.pop_front();
					errs += field_bad("status", 16'(want.status), 16'(got.status));
					errs += field_bad("ref_base", 16'(want.ref_base), 16'(got.ref_base));
					errs += field_bad("alt_base", 16'(want.alt_base), 16'(got.alt_base));
					errs += field_bad("ref_count", want.ref_count, got.ref_count);
					errs += field_bad("alt_count", want.alt_count, got.alt_count);
				end
			end
			pending <= pending_results.size();
			fail_count <= errs;
			results_seen <= seen;
		end
	end

endmodule

// File: dv/allele_pileup_count_table_test.sv
// Testbench top that drives the allele pileup count table and reports the verdict.
`timescale 1ns / 1ps

module allele_pileup_count_table_test;
	import apct_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_ITEMS = 90;
	localparam int STREAK_OBSERVES = 24;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  action;
	logic [11:0] position;
	logic [7:0]  base_code;
	logic        empty;
	logic        pop;
	logic [1:0]  status;
	logic [7:0]  ref_base;
	logic [7:0]  alt_base;
	logic [15:0] ref_count;
	logic [15:0] alt_count;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	int          pending;
	int          fail_count;
	int          results_seen;

	int          tx_gap_pct;
	int          rx_gap_pct;
	bit          hold_req;
	int          n_init;
	int          n_observe;
	int          n_read;
	int          n_unused;
	int          depth_writes;
	logic [11:0] hot_base;
	logic [11:0] live_pos [$];
	bit          is_live [4096];
	logic [7:0]  ref_of [4096];

	allele_pileup_count_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.action    (action),
		.position  (position),
		.base_code (base_code),
		.empty     (empty),
		.pop       (pop),
		.status    (status),
		.ref_base  (ref_base),
		.alt_base  (alt_base),
		.ref_count (ref_count),
		.alt_count (alt_count),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	apct_pileup_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.action       (action),
		.position     (position),
		.base_code    (base_code),
		.empty        (empty),
		.pop          (pop),
		.status       (status),
		.ref_base     (ref_base),
		.alt_base     (alt_base),
		.ref_count    (ref_count),
		.alt_count    (alt_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.pending      (pending),
		.fail_count   (fail_count),
		.results_seen (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		pop <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if ($urandom_range(0, 99) < rx_gap_pct) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Watchdog expired after %0d cycles without a transaction.", WATCHDOG_LIMIT);
		$display("allele_pileup_count_table_test failed");
		$finish;
	end

	task automatic send_item(input logic [1:0] act, input logic [11:0] pos,
			input logic [7:0] base);
		if ($urandom_range(0, 99) < tx_gap_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		push <= 1'b1;
		action <= act;
		position <= pos;
		base_code <= base;
		do @(posedge clk); while (full);
		case (act)
			ACT_INIT: begin
				n_init++;
				ref_of[pos] = base;
				if (!is_live[pos]) begin
					is_live[pos] = 1'b1;
					live_pos.push_back(pos);
				end
			end
			ACT_OBSERVE: n_observe++;
			ACT_READ: n_read++;
			default: n_unused++;
		endcase
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_depth(input logic [15:0] value);
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		depth_writes++;
	endtask

	task automatic random_item();
		int pick;
		int sel;
		int span;
		logic [11:0] pos;
		logic [7:0] base;
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			send_item(ACT_UNUSED, 12'($urandom), 8'($urandom));
		end else if (pick < 13 || live_pos.size() == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				pos = 12'($urandom);
			end else begin
				pos = hot_base + 12'($urandom_range(0, 15));
			end
			sel = $urandom_range(0, 9);
			base = (sel < 8) ? BASE_ORDER[sel % 4] : 8'($urandom);
			send_item(ACT_INIT, pos, base);
		end else begin
			span = (live_pos.size() < 24) ? live_pos.size() : 24;
			pos = live_pos[live_pos.size() - 1 - $urandom_range(0, span - 1)];
			if (pick < 35) begin
				send_item(ACT_READ, pos, 8'($urandom));
			end else begin
				sel = $urandom_range(0, 9);
				if (sel < 7) begin
					base = BASE_ORDER[$urandom_range(0, 3)];
				end else if (sel == 7) begin
					base = ref_of[pos];
				end else begin
					base = 8'($urandom);
				end
				send_item(ACT_OBSERVE, pos, base);
			end
		end
	endtask

	initial begin
		logic [15:0] depths [6];
		int goal;
		int p;
		arst_n <= 1'b0;
		push <= 1'b0;
		action <= ACT_INIT;
		position <= '0;
		base_code <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		tx_gap_pct = 0;
		rx_gap_pct = 0;
		hold_req = 1'b0;
		n_init = 0;
		n_observe = 0;
		n_read = 0;
		n_unused = 0;
		depth_writes = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed checks run with the read depth left at its reset value.
		send_item(ACT_INIT, 12'd0, BASE_A);
		send_item(ACT_INIT, 12'd4095, BASE_ORDER[1]);
		send_item(ACT_INIT, 12'd1, 8'hFF);
		send_item(ACT_INIT, 12'd2, 8'h00);
		send_item(ACT_OBSERVE, 12'd0, BASE_A);
		send_item(ACT_OBSERVE, 12'd0, BASE_ORDER[2]);
		send_item(ACT_OBSERVE, 12'd0, BASE_ORDER[3]);
		send_item(ACT_OBSERVE, 12'd0, BASE_ORDER[3]);
		send_item(ACT_OBSERVE, 12'd0, 8'hAA);
		send_item(ACT_READ, 12'd0, 8'h00);
		send_item(ACT_OBSERVE, 12'd4095, BASE_A);
		send_item(ACT_OBSERVE, 12'd4095, BASE_ORDER[1]);
		send_item(ACT_READ, 12'd4095, 8'hFF);
		send_item(ACT_OBSERVE, 12'd1, BASE_ORDER[2]);
		send_item(ACT_OBSERVE, 12'd1, BASE_ORDER[1]);
		send_item(ACT_READ, 12'd1, 8'h00);
		send_item(ACT_READ, 12'd2, 8'h00);
		send_item(ACT_UNUSED, 12'd4095, 8'hFF);

		// A zero read depth makes the first alternate observation clip the reference count.
		write_depth(16'd0);
		send_item(ACT_INIT, 12'd3, BASE_ORDER[3]);
		send_item(ACT_OBSERVE, 12'd3, BASE_ORDER[1]);
		send_item(ACT_READ, 12'd3, 8'h00);

		depths[0] = 16'hFFFF;
		depths[1] = 16'd1;
		depths[2] = 16'd0;
		depths[3] = 16'($urandom_range(2, 40));
		depths[4] = 16'($urandom);
		depths[5] = 16'd5;
		for (p = 0; p < 5; p++) begin
			write_depth(depths[p]);
			hot_base = 12'($urandom);
			case ($urandom_range(0, 2))
				0: tx_gap_pct = 0;
				1: tx_gap_pct = 15;
				default: tx_gap_pct = 35;
			endcase
			rx_gap_pct = (p == 0) ? 35 : 5 * $urandom_range(0, 8);
			if (p == 1) begin
				hold_req = 1'b1;
			end
			goal = n_init + n_observe + n_read + PHASE_ITEMS;
			while (n_init + n_observe + n_read < goal) random_item();
		end

		tx_gap_pct = 0;
		rx_gap_pct = 0;
		write_depth(16'hFFFF);
		send_item(ACT_INIT, 12'd2048, BASE_ORDER[1]);
		repeat (STREAK_OBSERVES) send_item(ACT_OBSERVE, 12'd2048, BASE_ORDER[2]);
		send_item(ACT_READ, 12'd2048, 8'h00);

		write_depth(depths[5]);
		hot_base = 12'($urandom);
		goal = n_init + n_observe + n_read + PHASE_ITEMS;
		while (n_init + n_observe + n_read < goal) random_item();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d init, %0d observe, %0d read and %0d unused-action transactions",
			n_init, n_observe, n_read, n_unused);
		$display("under %0d read depth writes, with %0d results checked.",
			depth_writes, results_seen);
		if (fail_count == 0) begin
			$display("allele_pileup_count_table_test passed");
		end else begin
			$display("allele_pileup_count_table_test failed");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/apct_pkg.sv
hw/rtl/apct_fifo.sv
hw/rtl/apct_front.sv
hw/rtl/apct_back.sv
hw/rtl/allele_pileup_count_table.sv
dv/apct_pileup_checker.sv
dv/allele_pileup_count_table_test.sv
